>>> src/smg_pkg.sv
// Shared types and constants for the silhouette mask generator.
// Depends on nothing; every other file imports it.
package smg_pkg;

   // Command codes on the request channel
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_KEY   = 2'd1;
   localparam logic [1:0] CMD_PIXEL = 2'd2;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;
   localparam logic [CSR_INDEX_W-1:0] REG_SAT_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LUM_THRESHOLD = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MARGIN_LEFT   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MARGIN_TOP    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MARGIN_RIGHT  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_MARGIN_BOTTOM = 3'd5;

   // Register reset values
   localparam logic [7:0] SAT_THRESHOLD_RST = 8'd30;
   localparam logic [7:0] LUM_THRESHOLD_RST = 8'd40;
   localparam logic [9:0] MARGIN_LEFT_RST   = 10'd35;
   localparam logic [8:0] MARGIN_TOP_RST    = 9'd35;
   localparam logic [9:0] MARGIN_RIGHT_RST  = 10'd30;
   localparam logic [8:0] MARGIN_BOTTOM_RST = 9'd10;

   localparam logic [7:0] CHAN_FULL = 8'd255;
   localparam logic [5:0] JOINT_COUNT_MAX = 6'd63;

   typedef struct packed {
      logic [1:0] command;
      logic [9:0] key_x;
      logic [9:0] key_y;
      logic [9:0] pixel_x;
      logic [9:0] pixel_y;
      logic [7:0] pixel_blue;
      logic [7:0] pixel_green;
      logic [7:0] pixel_red;
   } req_type;

   typedef struct packed {
      logic       foreground;
      logic [7:0] lightness;
      logic [7:0] saturation_value;
   } rsp_type;

   typedef struct packed {
      logic [7:0] sat_threshold;
      logic [7:0] lum_threshold;
      logic [9:0] margin_left;
      logic [8:0] margin_top;
      logic [9:0] margin_right;
      logic [8:0] margin_bottom;
   } cfg_type;

   typedef enum logic [1:0] {
      OP_START,
      OP_KEY,
      OP_PIXEL
   } op_type;

   // One classified work item as it travels from front to back
   typedef struct packed {
      op_type     op;
      logic [9:0] pos_x;
      logic [9:0] pos_y;
      logic [7:0] chan_max;
      logic [7:0] chan_min;
      logic       white;
   } work_type;

endpackage

>>> src/smg_front.sv
// Front end: accepts request transactions, decodes the command and reduces
// the pixel colour to max, min and a white flag. Depends on smg_pkg.
module smg_front
   import smg_pkg::*;
(
   input  logic     req_push,
   input  req_type  req_data,
   output logic     req_full,
   input  logic     q_full,
   output logic     q_push,
   output work_type q_wdata
);

   logic [7:0] max_bg;
   logic [7:0] min_bg;
   logic       keep;

   always_comb begin
      max_bg = (req_data.pixel_green > req_data.pixel_blue) ? req_data.pixel_green
                                                            : req_data.pixel_blue;
      min_bg = (req_data.pixel_green < req_data.pixel_blue) ? req_data.pixel_green
                                                            : req_data.pixel_blue;
      q_wdata.chan_max = (req_data.pixel_red > max_bg) ? req_data.pixel_red : max_bg;
      q_wdata.chan_min = (req_data.pixel_red < min_bg) ? req_data.pixel_red : min_bg;
      q_wdata.white    = (req_data.pixel_blue == CHAN_FULL) &&
                         (req_data.pixel_green == CHAN_FULL) &&
                         (req_data.pixel_red == CHAN_FULL);
      q_wdata.pos_x    = req_data.pixel_x;
      q_wdata.pos_y    = req_data.pixel_y;
      q_wdata.op       = OP_START;
      keep             = 1'b1;
      case (req_data.command)
         CMD_START: begin
            q_wdata.op = OP_START;
         end
         CMD_KEY: begin
            q_wdata.op    = OP_KEY;
            q_wdata.pos_x = req_data.key_x;
            q_wdata.pos_y = req_data.key_y;
         end
         CMD_PIXEL: begin
            q_wdata.op = OP_PIXEL;
         end
         default: begin
            // unused command: accept and drop
            keep = 1'b0;
         end
      endcase
   end

   assign req_full = q_full;
   assign q_push   = req_push && !q_full && keep;

endmodule

>>> src/smg_queue.sv
// Work queue between front and back, registered read port.
// Depends on smg_pkg.
module smg_queue
   import smg_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type wdata,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output work_type rdata
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   work_type         mem [DEPTH];
   work_type         rdata_ff;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = rdata_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wdata;
      end
      if (do_pop) begin
         rdata_ff <= mem[rd_ptr_ff];
      end
   end

endmodule

>>> src/smg_back.sv
// Back end: keypoint box state, HLS lightness and bit-serial saturation
// divide, mask decision and result register. Depends on smg_pkg.
module smg_back
   import smg_pkg::*;
#(
   parameter int JOINTS       = 25,
   parameter int IMAGE_WIDTH  = 640,
   parameter int IMAGE_HEIGHT = 480
)
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     q_empty,
   output logic     q_pop,
   input  work_type q_rdata,
   output logic     rsp_empty,
   input  logic     rsp_pop,
   output rsp_type  rsp_data
);

   localparam logic [9:0] BOX_MIN_X_RST = 10'(IMAGE_WIDTH);
   localparam logic [9:0] BOX_MIN_Y_RST = 10'(IMAGE_HEIGHT);
   localparam logic [5:0] JOINTS_W      = 6'(JOINTS);
   localparam int         QUOT_BITS     = 8;
   localparam int         STEP_W        = $clog2(QUOT_BITS);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QUOT_BITS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type         state_ff, state_in;
   logic [9:0]        min_x_ff, min_x_in;
   logic [9:0]        max_x_ff, max_x_in;
   logic [9:0]        min_y_ff, min_y_in;
   logic [9:0]        max_y_ff, max_y_in;
   logic [5:0]        joints_ff, joints_in;
   logic [7:0]        lum_ff, lum_in;
   logic              inside_ff, inside_in;
   logic              white_ff, white_in;
   logic [8:0]        div_den_ff, div_den_in;
   logic [8:0]        div_rem_ff, div_rem_in;
   logic [7:0]        div_low_ff, div_low_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [8:0]  sum;
   logic [7:0]  diff;
   logic [9:0]  sum_round;
   logic [7:0]  den;
   logic [16:0] numer;
   logic [9:0]  trial;
   logic        trial_ge;
   logic        pale;

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      sum       = {1'b0, q_rdata.chan_max} + {1'b0, q_rdata.chan_min};
      diff      = q_rdata.chan_max - q_rdata.chan_min;
      sum_round = {1'b0, sum} + 10'd1;
      den       = (sum < 9'd255) ? sum[7:0] : 8'(10'd510 - {1'b0, sum});
      // 510 * diff + den
      numer     = ({9'd0, diff} << 9) - ({9'd0, diff} << 1) + {9'd0, den};
      trial     = {div_rem_ff, div_low_ff[7]};
      trial_ge  = (trial >= {1'b0, div_den_ff});
      pale      = (div_low_ff < cfg.sat_threshold) && (lum_ff > cfg.lum_threshold);
   end

   always_comb begin
      state_in     = state_ff;
      min_x_in     = min_x_ff;
      max_x_in     = max_x_ff;
      min_y_in     = min_y_ff;
      max_y_in     = max_y_ff;
      joints_in    = joints_ff;
      lum_in       = lum_ff;
      inside_in    = inside_ff;
      white_in     = white_ff;
      div_den_in   = div_den_ff;
      div_rem_in   = div_rem_ff;
      div_low_in   = div_low_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;

      if (rsp_pop && rsp_valid_ff) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            case (q_rdata.op)
               OP_START: begin
                  min_x_in  = BOX_MIN_X_RST;
                  max_x_in  = '0;
                  min_y_in  = BOX_MIN_Y_RST;
                  max_y_in  = '0;
                  joints_in = '0;
               end
               OP_KEY: begin
                  if (q_rdata.pos_x != '0 && q_rdata.pos_x < min_x_ff) begin
                     min_x_in = q_rdata.pos_x;
                  end
                  if (q_rdata.pos_y != '0 && q_rdata.pos_y < min_y_ff) begin
                     min_y_in = q_rdata.pos_y;
                  end
                  if (q_rdata.pos_x > max_x_ff) begin
                     max_x_in = q_rdata.pos_x;
                  end
                  if (q_rdata.pos_y > max_y_ff) begin
                     max_y_in = q_rdata.pos_y;
                  end
                  if (joints_ff != JOINT_COUNT_MAX) begin
                     joints_in = joints_ff + 1'b1;
                  end
               end
               OP_PIXEL: begin
                  lum_in   = sum_round[8:1];
                  white_in = q_rdata.white;
                  // box test without signed math: x > min - m  <=>  x + m > min
                  inside_in = 1'b1;
                  if (joints_ff == JOINTS_W) begin
                     inside_in =
                        ({1'b0, q_rdata.pos_x} + {1'b0, cfg.margin_left} >
                         {1'b0, min_x_ff}) &&
                        ({1'b0, q_rdata.pos_x} <
                         {1'b0, max_x_ff} + {1'b0, cfg.margin_right}) &&
                        ({1'b0, q_rdata.pos_y} + {2'b0, cfg.margin_top} >
                         {1'b0, min_y_ff}) &&
                        ({1'b0, q_rdata.pos_y} <
                         {1'b0, max_y_ff} + {2'b0, cfg.margin_bottom});
                  end
                  div_den_in = {den, 1'b0};
                  div_rem_in = numer[16:8];
                  step_in    = '0;
                  if (diff == '0) begin
                     div_low_in = '0;
                     state_in   = ST_FINISH;
                  end else begin
                     div_low_in = numer[7:0];
                     state_in   = ST_DIVIDE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_DIVIDE: begin
            // one quotient bit per cycle; quotient shifts in behind the dividend
            div_rem_in = trial_ge ? 9'(trial - {1'b0, div_den_ff}) : trial[8:0];
            div_low_in = {div_low_ff[6:0], trial_ge};
            step_in    = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_pop) begin
               rsp_in.foreground       = inside_ff && !pale && !white_ff;
               rsp_in.lightness        = lum_ff;
               rsp_in.saturation_value = div_low_ff;
               rsp_valid_in            = 1'b1;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         min_x_ff     <= BOX_MIN_X_RST;
         max_x_ff     <= '0;
         min_y_ff     <= BOX_MIN_Y_RST;
         max_y_ff     <= '0;
         joints_ff    <= '0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         min_x_ff     <= min_x_in;
         max_x_ff     <= max_x_in;
         min_y_ff     <= min_y_in;
         max_y_ff     <= max_y_in;
         joints_ff    <= joints_in;
         step_ff      <= step_in;
      end
      lum_ff     <= lum_in;
      inside_ff  <= inside_in;
      white_ff   <= white_in;
      div_den_ff <= div_den_in;
      div_rem_ff <= div_rem_in;
      div_low_ff <= div_low_in;
      rsp_ff     <= rsp_in;
   end

endmodule

>>> src/silhouette_mask_generator_top.sv
// Top level of the silhouette mask generator: configuration registers,
// front end, work queue and back end. Depends on smg_pkg, smg_front,
// smg_queue and smg_back.
//
//   Request channel (req_push / req_full / req_data): one transaction per
//   start-frame, keypoint or pixel command. Command code 3 is accepted and
//   dropped. Result channel (rsp_empty / rsp_pop / rsp_data): one transaction
//   per pixel, in request order. CSR port (csr_write / csr_index / csr_wdata):
//   write thresholds and margins only while no transaction is in flight.
//   Sequencing: the back end runs one command at a time. Start and keypoint
//   commands pass through queue read and decode; a pixel passes through queue
//   read, decode, the one-bit-per-cycle saturation divider and result load,
//   while a gray pixel skips the divider. The divider sets the pixel rate;
//   the work queue (QUEUE_DEPTH entries) keeps the request side open while
//   the back end is busy.
//   Reset: thresholds and margins return to their defaults, the keypoint box
//   is cleared, queue and result register empty. Stall: a result not popped
//   holds in the output register; the back end waits on the next pixel, the
//   queue fills and req_full rises.
module silhouette_mask_generator_top
   import smg_pkg::*;
#(
   parameter int JOINTS       = 25,
   parameter int IMAGE_WIDTH  = 640,
   parameter int IMAGE_HEIGHT = 480,
   parameter int QUEUE_DEPTH  = 4
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  req_type                req_data,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output rsp_type                rsp_data,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   logic     q_push;
   logic     q_full;
   logic     q_pop;
   logic     q_empty;
   work_type q_wdata;
   work_type q_rdata;

   // CSR decode: keep the low bits of the write data for narrow registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_SAT_THRESHOLD: cfg_in.sat_threshold = csr_wdata[7:0];
            REG_LUM_THRESHOLD: cfg_in.lum_threshold = csr_wdata[7:0];
            REG_MARGIN_LEFT:   cfg_in.margin_left   = csr_wdata;
            REG_MARGIN_TOP:    cfg_in.margin_top    = csr_wdata[8:0];
            REG_MARGIN_RIGHT:  cfg_in.margin_right  = csr_wdata;
            REG_MARGIN_BOTTOM: cfg_in.margin_bottom = csr_wdata[8:0];
            default: begin
               // drop writes beyond the register list
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sat_threshold <= SAT_THRESHOLD_RST;
         cfg_ff.lum_threshold <= LUM_THRESHOLD_RST;
         cfg_ff.margin_left   <= MARGIN_LEFT_RST;
         cfg_ff.margin_top    <= MARGIN_TOP_RST;
         cfg_ff.margin_right  <= MARGIN_RIGHT_RST;
         cfg_ff.margin_bottom <= MARGIN_BOTTOM_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   smg_front u_front (
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_wdata  (q_wdata)
   );

   smg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .empty (q_empty),
      .rdata (q_rdata)
   );

   smg_back #(
      .JOINTS       (JOINTS),
      .IMAGE_WIDTH  (IMAGE_WIDTH),
      .IMAGE_HEIGHT (IMAGE_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_rdata   (q_rdata),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // The back end never reads from an empty queue
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("back end popped an empty work queue");

   // Nothing is waiting on the result side right after reset
   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> rsp_empty)
      else $error("result channel not empty after reset");

   // Full lightness with zero saturation is pure white, which is background
   a_white_background: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.lightness == CHAN_FULL &&
       rsp_data.saturation_value == '0) |-> !rsp_data.foreground)
      else $error("pure white pixel marked as foreground");

endmodule
